// ===== sv/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, codes and helpers shared by the heap resize policy block.
// ----------------------------------------------------------------------------
package hrp_pkg;

    // Field widths
    localparam int TimeW  = 32;
    localparam int BytesW = 48;
    localparam int DelayW = TimeW + 1;
    localparam int StateW = 2;
    localparam int ActW   = 3;

    // APB register map: one 64-bit register per 8-byte slot
    localparam int ApbDataW = 64;
    localparam int ApbAddrW = 4;
    localparam logic REG_DRAM_LIMIT = 1'b0;

    // Policy state, one-hot inside the block
    typedef enum logic [3:0] {
        S_NONE    = 4'b0001,
        S_WGROW   = 4'b0010,
        S_WSHRINK = 4'b0100,
        S_STABLE  = 4'b1000
    } t_state;

    // Encoded policy state as seen on the result channel
    localparam logic [StateW-1:0] ST_NONE    = 2'd0;
    localparam logic [StateW-1:0] ST_WGROW   = 2'd1;
    localparam logic [StateW-1:0] ST_WSHRINK = 2'd2;
    localparam logic [StateW-1:0] ST_STABLE  = 2'd3;

    // Resize actions
    typedef enum logic [ActW-1:0] {
        A_NONE     = 3'd0,
        A_GROW     = 3'd1,
        A_SHRINK   = 3'd2,
        A_WAITGROW = 3'd3,
        A_SLACK    = 3'd4
    } t_action;

    // One decision epoch as held in the input register
    typedef struct packed {
        logic [TimeW-1:0]  gc_time;
        logic [TimeW-1:0]  io_time;
        logic [BytesW-1:0] heap_capacity;
        logic [BytesW-1:0] heap_used;
        logic [BytesW-1:0] heap_max;
        logic [BytesW-1:0] anon_bytes;
        logic [BytesW-1:0] cache_bytes;
    } t_item;

    // One-hot state to output code
    function automatic logic [StateW-1:0] state_code(input t_state s);
        logic [StateW-1:0] c;
        case (s)
            S_WGROW:   c = ST_WGROW;
            S_WSHRINK: c = ST_WSHRINK;
            S_STABLE:  c = ST_STABLE;
            default:   c = ST_NONE;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/hrp_in_if.sv =====
// ----------------------------------------------------------------------------
// hrp_in_if
// Input channel: one decision epoch per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hrp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] gc_time;
    logic [31:0] io_time;
    logic [47:0] heap_capacity;
    logic [47:0] heap_used;
    logic [47:0] heap_max;
    logic [47:0] anon_bytes;
    logic [47:0] cache_bytes;

    modport source (
        output valid, gc_time, io_time, heap_capacity, heap_used, heap_max,
               anon_bytes, cache_bytes,
        input  ready
    );
    modport sink (
        input  valid, gc_time, io_time, heap_capacity, heap_used, heap_max,
               anon_bytes, cache_bytes,
        output ready
    );
endinterface

// ===== sv/hrp_out_if.sv =====
// ----------------------------------------------------------------------------
// hrp_out_if
// Result channel: next policy state and resize action, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hrp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] next_state;
    logic [2:0] action;

    modport source (
        output valid, next_state, action,
        input  ready
    );
    modport sink (
        input  valid, next_state, action,
        output ready
    );
endinterface

// ===== sv/hrp_cfg.sv =====
// ----------------------------------------------------------------------------
// hrp_cfg
// APB register file holding the DRAM budget used by the slack test.
// ----------------------------------------------------------------------------
module hrp_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hrp_pkg::ApbAddrW-1:0] paddr,
    input  logic [hrp_pkg::ApbDataW-1:0] pwdata,
    output logic [hrp_pkg::ApbDataW-1:0] prdata,
    output logic                         pready,
    output logic [hrp_pkg::BytesW-1:0]   o_dram_limit
);
    import hrp_pkg::*;

    logic              wr_en;
    logic              sel_limit;
    logic [BytesW-1:0] r_dram_limit;

    // Register slot is paddr[3]; low bits are the byte offset
    assign sel_limit = (paddr[3] == REG_DRAM_LIMIT);
    assign wr_en     = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Budget register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dram_limit <= '0;
        end else if (wr_en && sel_limit) begin
            r_dram_limit <= pwdata[BytesW-1:0];
        end
    end

    // Read back, zero for empty slots
    always_comb begin
        prdata = '0;
        if (sel_limit) begin
            prdata = {{(ApbDataW-BytesW){1'b0}}, r_dram_limit};
        end
    end

    assign o_dram_limit = r_dram_limit;

endmodule

// ===== sv/hrp_decide.sv =====
// ----------------------------------------------------------------------------
// hrp_decide
// Combinational policy decision for one epoch: flags, next state, action.
// ----------------------------------------------------------------------------
module hrp_decide (
    input  hrp_pkg::t_item              i_item,
    input  hrp_pkg::t_state             i_state,
    input  logic [hrp_pkg::DelayW-1:0]  i_last_delay,
    input  logic [hrp_pkg::BytesW-1:0]  i_dram_limit,
    output hrp_pkg::t_state             o_state,
    output hrp_pkg::t_action            o_action,
    output logic [hrp_pkg::DelayW-1:0]  o_delay
);
    import hrp_pkg::*;

    localparam int ProdW = BytesW + 4;

    logic [ProdW-1:0]  used_x10;
    logic [ProdW-1:0]  cap_x7;
    logic [BytesW:0]   mem_sum;
    logic [ProdW-1:0]  mem_x5;
    logic [ProdW-1:0]  lim_x4;
    logic              dec;
    logic              gc_gt;
    logic              io_gt;
    logic              under;
    logic              high;
    logic              slack;
    t_state            fresh_st;
    t_action           fresh_act;

    // Total delay this epoch, exact in 33 bits
    assign o_delay = {1'b0, i_item.gc_time} + {1'b0, i_item.io_time};
    assign dec     = o_delay < i_last_delay;
    assign gc_gt   = i_item.gc_time > i_item.io_time;
    assign io_gt   = i_item.io_time > i_item.gc_time;
    assign under   = i_item.heap_capacity < i_item.heap_max;

    // Occupancy above 0.70: used*10 > cap*7, shift and add
    assign used_x10 = {1'b0, i_item.heap_used, 3'b000}
                    + {3'b000, i_item.heap_used, 1'b0};
    assign cap_x7   = {1'b0, i_item.heap_capacity, 3'b000}
                    - {4'b0000, i_item.heap_capacity};
    assign high     = used_x10 > cap_x7;

    // Memory slack below 0.8: (anon+cache)*5 < limit*4
    assign mem_sum = {1'b0, i_item.anon_bytes} + {1'b0, i_item.cache_bytes};
    assign mem_x5  = {1'b0, mem_sum, 2'b00} + {3'b000, mem_sum};
    assign lim_x4  = {2'b00, i_dram_limit, 2'b00};
    assign slack   = mem_x5 < lim_x4;

    // Decision from scratch (no action state, stable state on no decrease)
    always_comb begin
        if (!io_gt && under) begin
            fresh_st  = S_WGROW;
            fresh_act = A_GROW;
        end else if (io_gt) begin
            fresh_st  = S_WSHRINK;
            fresh_act = A_SHRINK;
        end else begin
            fresh_st  = S_NONE;
            fresh_act = A_NONE;
        end
    end

    // Per-state transition
    always_comb begin
        o_state  = S_NONE;
        o_action = A_NONE;
        case (i_state)
            S_WGROW: begin
                if (gc_gt && high && under && dec) begin
                    o_state  = S_WGROW;
                    o_action = A_GROW;
                end else if (gc_gt && !dec) begin
                    o_state  = S_WGROW;
                    o_action = A_GROW;
                end else if (gc_gt && !high && under && dec) begin
                    o_state  = S_WGROW;
                    o_action = A_WAITGROW;
                end else if (io_gt || !dec) begin
                    o_state  = S_WSHRINK;
                    o_action = A_SHRINK;
                end
            end
            S_WSHRINK: begin
                if (io_gt && dec) begin
                    o_state  = S_WSHRINK;
                    o_action = slack ? A_SLACK : A_SHRINK;
                end else if (gc_gt || !dec) begin
                    o_state  = S_WGROW;
                    o_action = A_GROW;
                end
            end
            S_STABLE: begin
                if (dec) begin
                    o_state  = S_STABLE;
                    o_action = A_NONE;
                end else begin
                    o_state  = fresh_st;
                    o_action = fresh_act;
                end
            end
            default: begin
                o_state  = fresh_st;
                o_action = fresh_act;
            end
        endcase
    end

endmodule

// ===== sv/heap_resize_policy_fsm_stable_top.sv =====
// ----------------------------------------------------------------------------
// heap_resize_policy_fsm_stable_top
// Heap resize policy state machine: one decision per epoch item.
//
//   Channel  Dir  Handshake            Payload
//   i_in     in   valid/ready          gc/io time, heap sizes, memory bytes
//   o_out    out  valid/ready          next_state, action
//   APB      in   psel/penable/pready  dram_limit at byte address 0
//
// One item per cycle sustained while the result channel is ready; an accepted
// item passes through the input register, then the result register.
// Policy state and last delay update as an item moves into the result
// register, so consecutive items see each other's effect without a gap.
// A stalled result holds in the result register while one more item waits
// in the input register. Synchronous active-low reset empties both stages.
// ----------------------------------------------------------------------------
module heap_resize_policy_fsm_stable_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    hrp_in_if.sink                       i_in,
    hrp_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hrp_pkg::ApbAddrW-1:0] paddr,
    input  logic [hrp_pkg::ApbDataW-1:0] pwdata,
    output logic [hrp_pkg::ApbDataW-1:0] prdata,
    output logic                         pready
);
    import hrp_pkg::*;

    logic              r_in_vld;
    t_item             r_item;
    logic              r_out_vld;
    logic [StateW-1:0] r_next_state;
    t_action           r_action;
    t_state            r_state;
    logic [DelayW-1:0] r_last_delay;

    t_state            n_state;
    t_action           n_action;
    logic [DelayW-1:0] n_delay;
    logic [BytesW-1:0] dram_limit;
    logic              out_free;
    logic              adv;

    // Configuration registers
    hrp_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_dram_limit (dram_limit)
    );

    // Decision logic between the two registers
    hrp_decide u_decide (
        .i_item       (r_item),
        .i_state      (r_state),
        .i_last_delay (r_last_delay),
        .i_dram_limit (dram_limit),
        .o_state      (n_state),
        .o_action     (n_action),
        .o_delay      (n_delay)
    );

    // Flow control
    assign out_free   = !r_out_vld || o_out.ready;
    assign adv        = r_in_vld && out_free;
    assign i_in.ready = !r_in_vld || out_free;

    // Control and policy state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_state      <= S_NONE;
            r_last_delay <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (adv) begin
                r_state      <= n_state;
                r_last_delay <= n_delay;
            end
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.gc_time       <= i_in.gc_time;
            r_item.io_time       <= i_in.io_time;
            r_item.heap_capacity <= i_in.heap_capacity;
            r_item.heap_used     <= i_in.heap_used;
            r_item.heap_max      <= i_in.heap_max;
            r_item.anon_bytes    <= i_in.anon_bytes;
            r_item.cache_bytes   <= i_in.cache_bytes;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_next_state <= state_code(n_state);
            r_action     <= n_action;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.next_state = r_next_state;
    assign o_out.action     = r_action;

endmodule

// ===== sv/hrp_chk.sv =====
// ----------------------------------------------------------------------------
// hrp_chk
// Port-level checks for the heap resize policy block, bound to the top level.
// ----------------------------------------------------------------------------
module hrp_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_next_state,
    input logic [2:0] i_action
);
    import hrp_pkg::*;

    // Reset empties the result stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // An accepted item reaches the output once the result stage is free
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 (!i_out_valid || i_out_ready) |=> i_out_valid)
        else $error("accepted item did not reach the result stage");

    // Grow and wait after grow only come with the wait grow state
    a_grow_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_action == A_GROW || i_action == A_WAITGROW)
            |-> i_next_state == ST_WGROW)
        else $error("grow action without wait grow state");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready
            |=> i_out_valid && $stable(i_next_state) && $stable(i_action))
        else $error("stalled result changed");

endmodule

bind heap_resize_policy_fsm_stable_top hrp_chk u_hrp_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_next_state (o_out.next_state),
    .i_action     (o_out.action)
);

// ===== tb/sv/hrp_policy_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_policy_checker
// Watches the epoch and decision channels and the APB port of the heap
// resize policy block. It tracks dram_limit, the policy state and the last
// total delay, predicts the decision for each accepted epoch, and compares
// every accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module hrp_policy_checker
    import hrp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    hrp_in_if                   in_mon,
    hrp_out_if                  out_mon,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [ApbAddrW-1:0] i_paddr,
    input  logic [ApbDataW-1:0] i_pwdata,
    input  logic                i_pready,
    output int                  o_fails,
    output int                  o_pending,
    output int                  o_results,
    output int                  o_grows,
    output int                  o_shrinks,
    output int                  o_waitgrows,
    output int                  o_slacks
);

    localparam logic [ApbAddrW-1:0] LimitAddr = {REG_DRAM_LIMIT, 3'b000};

    typedef struct packed {
        logic [StateW-1:0] next_state;
        t_action           action;
    } t_decision;

    // Predictor copy of the block's state and register
    logic [BytesW-1:0] dram_limit;
    logic [StateW-1:0] pol_state;
    logic [DelayW-1:0] prev_delay;
    t_decision         pending_decisions[$];

    function automatic t_decision decision_of(input logic [StateW-1:0] st, input t_action act);
        t_decision d;
        d.next_state = st;
        d.action     = act;
        return d;
    endfunction

    // No action state rule, also used by stable when the delay did not drop
    function automatic t_decision fresh_decision(input logic io_gt, input logic under);
        if (!io_gt && under) return decision_of(ST_WGROW, A_GROW);
        if (io_gt) return decision_of(ST_WSHRINK, A_SHRINK);
        return decision_of(ST_NONE, A_NONE);
    endfunction

    // Next state and action for one epoch; updates policy state and delay
    function automatic t_decision decide_epoch(input t_item e);
        logic [DelayW-1:0] delay;
        logic [63:0]       used_x10, cap_x7, mem_x5, lim_x4;
        logic              dec, gc_gt, io_gt, under, high, slack;
        t_decision         d;
        delay    = {1'b0, e.gc_time} + {1'b0, e.io_time};
        dec      = delay < prev_delay;
        gc_gt    = e.gc_time > e.io_time;
        io_gt    = e.io_time > e.gc_time;
        under    = e.heap_capacity < e.heap_max;
        used_x10 = {16'd0, e.heap_used} * 64'd10;
        cap_x7   = {16'd0, e.heap_capacity} * 64'd7;
        high     = used_x10 > cap_x7;
        mem_x5   = ({16'd0, e.anon_bytes} + {16'd0, e.cache_bytes}) * 64'd5;
        lim_x4   = {16'd0, dram_limit} * 64'd4;
        slack    = mem_x5 < lim_x4;
        prev_delay = delay;
        case (pol_state)
            ST_WGROW: begin
                if (gc_gt && high && under && dec) d = decision_of(ST_WGROW, A_GROW);
                else if (gc_gt && !dec) d = decision_of(ST_WGROW, A_GROW);
                else if (gc_gt && !high && under && dec) d = decision_of(ST_WGROW, A_WAITGROW);
                else if (io_gt || !dec) d = decision_of(ST_WSHRINK, A_SHRINK);
                else d = decision_of(ST_NONE, A_NONE);
            end
            ST_WSHRINK: begin
                if (io_gt && slack && dec) d = decision_of(ST_WSHRINK, A_SLACK);
                else if (io_gt && !slack && dec) d = decision_of(ST_WSHRINK, A_SHRINK);
                else if (gc_gt || !dec) d = decision_of(ST_WGROW, A_GROW);
                else d = decision_of(ST_NONE, A_NONE);
            end
            ST_STABLE: begin
                if (dec) d = decision_of(ST_STABLE, A_NONE);
                else d = fresh_decision(io_gt, under);
            end
            default: d = fresh_decision(io_gt, under);
        endcase
        pol_state = d.next_state;
        return d;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on result %0d: %s got %0d, expected %0d",
                 $time, o_results, what, got, want);
        o_fails++;
    endtask

    initial begin
        o_fails     = 0;
        o_pending   = 0;
        o_results   = 0;
        o_grows     = 0;
        o_shrinks   = 0;
        o_waitgrows = 0;
        o_slacks    = 0;
        dram_limit  = '0;
        pol_state   = ST_NONE;
        prev_delay  = '0;
    end

    // Register writes, result checks, then prediction for the accepted epoch
    always @(posedge i_clk) begin
        t_item     e;
        t_decision d;
        if (!i_rst_n) begin
            dram_limit = '0;
            pol_state  = ST_NONE;
            prev_delay = '0;
            pending_decisions.delete();
            o_pending  = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == LimitAddr)
                dram_limit = i_pwdata[BytesW-1:0];

            if (out_mon.valid && out_mon.ready) begin
                if (pending_decisions.size() == 0) begin
                    report_mismatch("result with nothing pending, action", out_mon.action, 0);
                end else begin
                    d = pending_decisions.pop_front();
                    o_pending--;
                    if (out_mon.next_state !== d.next_state)
                        report_mismatch("next_state", out_mon.next_state, d.next_state);
                    if (out_mon.action !== d.action)
                        report_mismatch("action", out_mon.action, d.action);
                    o_results++;
                end
            end

            if (in_mon.valid && in_mon.ready) begin
                e.gc_time       = in_mon.gc_time;
                e.io_time       = in_mon.io_time;
                e.heap_capacity = in_mon.heap_capacity;
                e.heap_used     = in_mon.heap_used;
                e.heap_max      = in_mon.heap_max;
                e.anon_bytes    = in_mon.anon_bytes;
                e.cache_bytes   = in_mon.cache_bytes;
                d = decide_epoch(e);
                case (d.action)
                    A_GROW:     o_grows++;
                    A_SHRINK:   o_shrinks++;
                    A_WAITGROW: o_waitgrows++;
                    A_SLACK:    o_slacks++;
                    default:    ;
                endcase
                pending_decisions.push_back(d);
                o_pending++;
            end
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the heap resize policy block with a directed walk of every
// reachable rule, then random epochs under several dram_limit settings
// with random idling on both channels. The checker beside the block
// predicts and compares each decision; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import hrp_pkg::*;

    localparam logic [ApbAddrW-1:0] LimitAddr  = {REG_DRAM_LIMIT, 3'b000};
    localparam int                  PhaseItems = 280;
    localparam logic [BytesW-1:0]   BytesMax   = {BytesW{1'b1}};
    localparam logic [TimeW-1:0]    TimeMax    = {TimeW{1'b1}};

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    int fails, pending, results, grows, shrinks, waitgrows, slacks;

    // Idling odds: 0 means none, else one burst per n chances on average
    int gap_odds;
    int stall_odds;
    logic [BytesW-1:0] cur_limit;
    int n_limits;

    hrp_in_if  in_ch ();
    hrp_out_if out_ch ();

    heap_resize_policy_fsm_stable_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hrp_policy_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_fails     (fails),
        .o_pending   (pending),
        .o_results   (results),
        .o_grows     (grows),
        .o_shrinks   (shrinks),
        .o_waitgrows (waitgrows),
        .o_slacks    (slacks)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // Result side back-pressure in random bursts
    initial begin : result_stall
        int hold;
        hold = 0;
        out_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_odds == 0) hold = 0;
            else if (hold > 0) hold--;
            else if ($urandom_range(1, stall_odds) == 1) hold = $urandom_range(1, 7);
            out_ch.ready = (hold == 0);
        end
    end

    function automatic logic [TimeW-1:0] pick_time();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return TimeMax - $urandom_range(0, 3);
            2: return $urandom_range(0, 3);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    function automatic logic [BytesW-1:0] pick_bytes();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return BytesMax;
            1: return '0;
            2: return BytesW'($urandom_range(0, 1000));
            default: return r[BytesW-1:0];
        endcase
    endfunction

    // Random epoch, biased towards the occupancy, limit and slack boundaries
    function automatic t_item make_epoch();
        t_item       e;
        logic [63:0] wide;
        logic [63:0] part;
        e.gc_time = pick_time();
        e.io_time = ($urandom_range(0, 4) == 0) ? e.gc_time : pick_time();
        e.heap_capacity = pick_bytes();
        case ($urandom_range(0, 3))
            0: e.heap_max = e.heap_capacity;
            1: e.heap_max = e.heap_capacity + 1'b1;
            2: e.heap_max = e.heap_capacity - 1'b1;
            default: e.heap_max = pick_bytes();
        endcase
        if ($urandom_range(0, 1) == 0) begin
            wide = {16'd0, e.heap_capacity} * 64'd7 / 64'd10
                 + 64'($urandom_range(0, 2)) - 64'd1;
            e.heap_used = wide[BytesW-1:0];
        end else begin
            e.heap_used = pick_bytes();
        end
        if (cur_limit != '0 && $urandom_range(0, 1) == 0) begin
            // total memory just either side of 0.8 of the limit
            wide = {16'd0, cur_limit} * 64'd4 / 64'd5
                 + 64'($urandom_range(0, 2)) - 64'd1;
            part = wide * 64'($urandom_range(0, 8)) / 64'd8;
            e.anon_bytes  = part[BytesW-1:0];
            e.cache_bytes = wide[BytesW-1:0] - part[BytesW-1:0];
        end else begin
            e.anon_bytes  = pick_bytes();
            e.cache_bytes = pick_bytes();
        end
        return e;
    endfunction

    task automatic write_limit(input logic [BytesW-1:0] lim);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = LimitAddr;
        pwdata  = {16'($urandom_range(0, 16'hFFFF)), lim};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        cur_limit = lim;
        n_limits++;
    endtask

    // One epoch item on the input channel; returns at the falling edge
    task automatic send_epoch(input t_item e);
        int n;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            in_ch.valid = 1'b0;
            n = $urandom_range(1, 7);
            repeat (n) @(negedge i_clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.gc_time       = e.gc_time;
        in_ch.io_time       = e.io_time;
        in_ch.heap_capacity = e.heap_capacity;
        in_ch.heap_used     = e.heap_used;
        in_ch.heap_max      = e.heap_max;
        in_ch.anon_bytes    = e.anon_bytes;
        in_ch.cache_bytes   = e.cache_bytes;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic directed_epoch(input logic [TimeW-1:0] gc, input logic [TimeW-1:0] io,
                                  input logic [BytesW-1:0] cap, input logic [BytesW-1:0] used,
                                  input logic [BytesW-1:0] hmax, input logic [BytesW-1:0] anon,
                                  input logic [BytesW-1:0] cache);
        t_item e;
        e.gc_time       = gc;
        e.io_time       = io;
        e.heap_capacity = cap;
        e.heap_used     = used;
        e.heap_max      = hmax;
        e.anon_bytes    = anon;
        e.cache_bytes   = cache;
        send_epoch(e);
    endtask

    // Hold the sender until every predicted decision has come out
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [BytesW-1:0] limits[6];
        logic [63:0]       r;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_ch.valid         = 1'b0;
        in_ch.gc_time       = '0;
        in_ch.io_time       = '0;
        in_ch.heap_capacity = '0;
        in_ch.heap_used     = '0;
        in_ch.heap_max      = '0;
        in_ch.anon_bytes    = '0;
        in_ch.cache_bytes   = '0;
        gap_odds            = 3;
        stall_odds          = 4;
        cur_limit           = '0;
        n_limits            = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed walk: slack when anon+cache is below 800
        write_limit(48'd1000);
        directed_epoch(0, 0, 0, 0, 0, 0, 0);            // idle epoch, no action
        directed_epoch(5, 0, 0, 0, 1, 0, 0);            // grow from no action
        directed_epoch(9, 0, 0, 0, 1, 0, 0);            // delay rose: keep growing
        directed_epoch(8, 0, 100, 71, 200, 0, 0);       // occupancy just above 0.70
        directed_epoch(7, 0, 100, 70, 200, 0, 0);       // exactly 0.70: wait after grow
        directed_epoch(6, 0, 0, 1, 1, 0, 0);            // zero capacity, used nonzero
        directed_epoch(5, 0, 0, 0, 1, 0, 0);            // zero capacity, nothing used
        directed_epoch(4, 0, 10, 0, 10, 0, 0);          // at the limit: back to no action
        directed_epoch(0, 3, 0, 0, 0, 0, 0);            // shrink from no action
        directed_epoch(0, 2, 0, 0, 0, 400, 399);        // just under 0.8: io slack
        directed_epoch(0, 1, 0, 0, 0, 400, 400);        // exactly 0.8: shrink
        directed_epoch(0, 5, 0, 0, 0, 0, 0);            // delay rose: grow
        directed_epoch(2, 2, 0, 0, 0, 0, 0);            // equal times, delay fell
        directed_epoch(3, 3, 5, 0, 5, 0, 0);            // equal times at the limit
        directed_epoch(3, 3, 4, 0, 5, 0, 0);            // equal times under the limit
        directed_epoch(1, 9, 0, 0, 0, 0, 0);            // I/O dominates while growing
        directed_epoch(2, 2, 0, 0, 0, 0, 0);            // equal times out of shrink
        directed_epoch(0, 7, 0, 0, 0, 0, 0);
        directed_epoch(4, 4, 0, 0, 0, 0, 0);            // shrink wait, delay rose
        directed_epoch(5, 5, 0, 0, 0, 0, 0);            // grow wait, equal, delay rose
        directed_epoch(TimeMax, TimeMax, BytesMax, BytesMax, BytesMax, BytesMax, BytesMax);
        directed_epoch(TimeMax, 0, BytesMax, BytesMax, BytesMax, BytesMax, BytesMax);
        wait_drained();

        // Random phases, one dram_limit setting each; the last has no idling
        r = {$urandom, $urandom};
        limits[0] = BytesMax;
        limits[1] = '0;
        limits[2] = r[BytesW-1:0];
        limits[3] = BytesW'($urandom_range(1, 5000));
        limits[4] = {1'b1, {(BytesW-1){1'b0}}};
        r = {$urandom, $urandom};
        limits[5] = r[BytesW-1:0];
        for (int p = 0; p < 6; p++) begin
            write_limit(limits[p]);
            case (p)
                1: begin gap_odds = 0; stall_odds = 2; end
                2: begin gap_odds = 2; stall_odds = 0; end
                5: begin gap_odds = 0; stall_odds = 0; end
                default: begin gap_odds = $urandom_range(2, 8); stall_odds = $urandom_range(2, 8); end
            endcase
            for (int k = 0; k < PhaseItems; k++) send_epoch(make_epoch());
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        $display("Checked %0d decisions over %0d dram_limit settings.", results, n_limits);
        $display("Predicted actions: grow %0d, shrink %0d, wait after grow %0d, io slack %0d.",
                 grows, shrinks, waitgrows, slacks);
        if (fails == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
